@@ design/i2cms_pkg.sv @@
// Shared types and constants for the I2C master status sequencer.
package i2cms_pkg;

   // Operation codes of the request beat.
   localparam logic OP_START = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // Controller status codes that the sequencer acts on.
   // Repeated start and arbitration lost are not listed; they fall to the error arm.
   localparam logic [7:0] ST_START_SENT   = 8'h08;
   localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
   localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

   // Control mask bits.
   localparam logic [3:0] CTL_ACK   = 4'b0001;
   localparam logic [3:0] CTL_STOP  = 4'b0010;
   localparam logic [3:0] CTL_START = 4'b0100;
   localparam logic [3:0] CTL_EN    = 4'b1000;
   localparam logic [3:0] CTL_SI    = 4'b1000;

   // Outcome codes.
   localparam logic [1:0] OUT_BUSY = 2'd0;
   localparam logic [1:0] OUT_DONE = 2'd1;
   localparam logic [1:0] OUT_ERR  = 2'd2;
   localparam logic [1:0] OUT_IDLE = 2'd3;

   typedef struct packed {
      logic       opcode;
      logic [7:0] address_byte;
      logic       direction;
      logic [7:0] length;
      logic [7:0] status_code;
      logic [7:0] rx_data;
      logic [7:0] tx_data;
   } req_type;

   typedef struct packed {
      logic       data_write_valid;
      logic [7:0] data_write_byte;
      logic       tx_consumed;
      logic [3:0] control_set;
      logic [3:0] control_clear;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [1:0] outcome;
   } rsp_type;

endpackage

@@ design/i2cms_core.sv @@
// Transfer state registers and the single-pass status decode.
module i2cms_core
   import i2cms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output rsp_type rsp
);

   logic       active_ff, active_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] addr_dir_ff, addr_dir_in;
   logic [7:0] rem_dec;

   assign rem_dec = (remaining_ff == 8'd0) ? 8'd0 : remaining_ff - 8'd1;

   always_comb begin
      rsp          = '0;
      rsp.outcome  = OUT_BUSY;
      active_in    = active_ff;
      remaining_in = remaining_ff;
      addr_dir_in  = addr_dir_ff;

      if (req.opcode == OP_START) begin
         addr_dir_in       = req.address_byte + {7'd0, req.direction};
         remaining_in      = req.length;
         active_in         = 1'b1;
         rsp.control_set   = CTL_EN | CTL_START;
         rsp.control_clear = CTL_SI;
      end else if (!active_ff) begin
         rsp.outcome = OUT_IDLE;
      end else begin
         unique case (req.status_code) inside
            ST_START_SENT: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_write_byte  = addr_dir_ff;
               rsp.control_clear    = CTL_START | CTL_STOP | CTL_SI;
            end
            ST_SLA_W_ACK: begin
               if (remaining_ff != 8'd0) begin
                  remaining_in         = rem_dec;
                  rsp.data_write_valid = 1'b1;
                  rsp.data_write_byte  = req.tx_data;
                  rsp.tx_consumed      = 1'b1;
                  rsp.control_clear    = CTL_SI;
               end else begin
                  rsp.outcome = OUT_ERR;
               end
            end
            ST_SLA_W_NACK, ST_SLA_R_NACK: begin
               rsp.control_clear = CTL_START;
               rsp.outcome       = OUT_ERR;
            end
            ST_DATA_TX_ACK: begin
               if (remaining_ff != 8'd0) begin
                  remaining_in         = rem_dec;
                  rsp.data_write_valid = 1'b1;
                  rsp.data_write_byte  = req.tx_data;
                  rsp.tx_consumed      = 1'b1;
                  rsp.control_clear    = CTL_START | CTL_STOP | CTL_SI;
               end else begin
                  rsp.control_set   = CTL_STOP;
                  rsp.control_clear = CTL_START | CTL_SI;
                  rsp.outcome       = OUT_DONE;
               end
            end
            ST_DATA_TX_NACK: begin
               rsp.control_clear = CTL_START;
               rsp.control_set   = CTL_STOP;
               rsp.outcome       = OUT_ERR;
            end
            ST_SLA_R_ACK, ST_DATA_RX_ACK: begin
               // ACK the next byte only while more than the current one remains.
               remaining_in = rem_dec;
               if (rem_dec != 8'd0) begin
                  rsp.control_set   = CTL_ACK;
                  rsp.control_clear = CTL_START | CTL_STOP | CTL_SI;
               end else begin
                  rsp.control_clear = CTL_START | CTL_STOP | CTL_SI | CTL_ACK;
               end
               if (req.status_code == ST_DATA_RX_ACK) begin
                  rsp.rx_valid = 1'b1;
                  rsp.rx_byte  = req.rx_data;
               end
            end
            ST_DATA_RX_NACK: begin
               if (remaining_ff != 8'd0) begin
                  rsp.outcome = OUT_ERR;
               end else begin
                  rsp.rx_valid = 1'b1;
                  rsp.rx_byte  = req.rx_data;
                  rsp.outcome  = OUT_DONE;
               end
               rsp.control_clear = CTL_START | CTL_SI;
               rsp.control_set   = CTL_STOP;
            end
            default: begin
               rsp.outcome = OUT_ERR;
            end
         endcase
         if (rsp.outcome != OUT_BUSY) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         remaining_ff <= 8'd0;
         addr_dir_ff  <= 8'd0;
      end else if (accept) begin
         active_ff    <= active_in;
         remaining_ff <= remaining_in;
         addr_dir_ff  <= addr_dir_in;
      end
   end

endmodule

@@ design/i2cms_outbuf.sv @@
// Two-entry result buffer: an output register with a skid register behind it.
module i2cms_outbuf
   import i2cms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign pop       = head_valid_ff && !out_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         // Head is free this cycle; the skid entry is older than a new beat.
         head_valid_in = skid_valid_ff || push;
         head_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

@@ design/i2c_master_status_sequencer_unit.sv @@
// Top level of the I2C master status sequencer: decode core and result buffer.
// Throughput: one request beat per cycle while the result buffer is not full; the status decode is combinational.
// The two-entry result buffer lets one more beat in while a result is stalled.
// Reset (synchronous, active high) clears the transfer state and empties the buffer.
module i2c_master_status_sequencer_unit
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_address_byte,
   input  logic       req_direction,
   input  logic [7:0] req_length,
   input  logic [7:0] req_status_code,
   input  logic [7:0] req_rx_data,
   input  logic [7:0] req_tx_data,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_data_write_valid,
   output logic [7:0] rsp_data_write_byte,
   output logic       rsp_tx_consumed,
   output logic [3:0] rsp_control_set,
   output logic [3:0] rsp_control_clear,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [1:0] rsp_outcome
);

   // The request beat is gathered into one struct for the decode core.
   req_type req;
   rsp_type core_rsp;
   rsp_type buf_rsp;
   logic    accept;
   logic    buf_full;

   assign req.opcode       = req_opcode;
   assign req.address_byte = req_address_byte;
   assign req.direction    = req_direction;
   assign req.length       = req_length;
   assign req.status_code  = req_status_code;
   assign req.rx_data      = req_rx_data;
   assign req.tx_data      = req_tx_data;

   // Requests are held off only when both buffer entries are occupied, which keeps
   // the stall registered and independent of the downstream stall in this cycle.
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // The core updates the transfer state and computes the result of an accepted beat
   // in the same cycle; the result is captured by the buffer at that edge.
   i2cms_core u_core (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req),
      .rsp   (core_rsp)
   );

   i2cms_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(core_rsp),
      .full     (buf_full),
      .out_valid(rsp_valid),
      .out_data (buf_rsp),
      .out_stall(rsp_stall)
   );

   // Result beat fields straight from the buffer head register.
   assign rsp_data_write_valid = buf_rsp.data_write_valid;
   assign rsp_data_write_byte  = buf_rsp.data_write_byte;
   assign rsp_tx_consumed      = buf_rsp.tx_consumed;
   assign rsp_control_set      = buf_rsp.control_set;
   assign rsp_control_clear    = buf_rsp.control_clear;
   assign rsp_rx_valid         = buf_rsp.rx_valid;
   assign rsp_rx_byte          = buf_rsp.rx_byte;
   assign rsp_outcome          = buf_rsp.outcome;

endmodule

@@ tb/sv/i2c_master_status_sequencer_unit_tb.sv @@
// Self-checking testbench for the I2C master status sequencer with a built-in action predictor.
module i2c_master_status_sequencer_unit_tb
   import i2cms_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Status codes that the block does not list. Both of them must end the transfer in error.
   localparam logic [7:0] ST_REPEATED_START = 8'h10;
   localparam logic [7:0] ST_ARB_LOST       = 8'h38;

   // The number of beats that change the block's state. Ignored idle events do not count.
   localparam int unsigned RANDOM_BEATS    = 1550;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   // Hand-written answers for the rows of the directed table whose result is obvious.
   localparam rsp_type START_ACTION =
      {1'b0, 8'h00, 1'b0, CTL_EN | CTL_START, CTL_SI, 1'b0, 8'h00, OUT_BUSY};
   localparam rsp_type IDLE_ACTION =
      {1'b0, 8'h00, 1'b0, 4'b0000, 4'b0000, 1'b0, 8'h00, OUT_IDLE};
   localparam rsp_type BARE_ERROR =
      {1'b0, 8'h00, 1'b0, 4'b0000, 4'b0000, 1'b0, 8'h00, OUT_ERR};
   localparam rsp_type ADDR_NACK_ERROR =
      {1'b0, 8'h00, 1'b0, 4'b0000, CTL_START, 1'b0, 8'h00, OUT_ERR};
   localparam rsp_type DATA_NACK_ERROR =
      {1'b0, 8'h00, 1'b0, CTL_STOP, CTL_START, 1'b0, 8'h00, OUT_ERR};
   localparam rsp_type EARLY_NACK_ERROR =
      {1'b0, 8'h00, 1'b0, CTL_STOP, CTL_START | CTL_SI, 1'b0, 8'h00, OUT_ERR};

   // One row of the directed table. When typed is set, golden is the expected result;
   // otherwise the predictor supplies it.
   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type golden;
   } directed_row_type;

   logic       clock;
   logic       reset;

   logic       req_valid;
   logic       req_stall;
   logic       req_opcode;
   logic [7:0] req_address_byte;
   logic       req_direction;
   logic [7:0] req_length;
   logic [7:0] req_status_code;
   logic [7:0] req_rx_data;
   logic [7:0] req_tx_data;

   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_data_write_valid;
   logic [7:0] rsp_data_write_byte;
   logic       rsp_tx_consumed;
   logic [3:0] rsp_control_set;
   logic [3:0] rsp_control_clear;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic [1:0] rsp_outcome;

   // The predictor's own copy of the transfer state. Reset is applied only once, at the start,
   // so the reset values are given here.
   logic       txn_active  = 1'b0;
   logic [8:0] bytes_left  = 9'd0;
   logic [7:0] target_byte = 8'h00;

   rsp_type          expected_actions[$];
   directed_row_type directed_rows[$];

   int unsigned send_idle_pct    = 29;
   int unsigned rcv_idle_pct     = 67;
   logic        hold_off_pending = 1'b0;
   int unsigned state_beats      = 0;
   int unsigned error_count      = 0;
   int unsigned cycle_count      = 0;

   i2c_master_status_sequencer_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_address_byte     (req_address_byte),
      .req_direction        (req_direction),
      .req_length           (req_length),
      .req_status_code      (req_status_code),
      .req_rx_data          (req_rx_data),
      .req_tx_data          (req_tx_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_write_valid (rsp_data_write_valid),
      .rsp_data_write_byte  (rsp_data_write_byte),
      .rsp_tx_consumed      (rsp_tx_consumed),
      .rsp_control_set      (rsp_control_set),
      .rsp_control_clear    (rsp_control_clear),
      .rsp_rx_valid         (rsp_rx_valid),
      .rsp_rx_byte          (rsp_rx_byte),
      .rsp_outcome          (rsp_outcome)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The run is stopped here if the block hangs. The limit is many times the slowest
   // correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("i2c_master_status_sequencer_unit_tb: errors");
         $finish;
      end
   end

   // Works out the controller action for one accepted request beat and advances the
   // predicted transfer state. A start beat always restarts the transfer, even while one
   // is running. A status event with no transfer running changes nothing.
   function automatic rsp_type next_action(input req_type b);
      rsp_type a;
      a = '0;
      a.outcome = OUT_BUSY;
      if (b.opcode == OP_START) begin
         // The address plus the direction bit wraps to eight bits.
         target_byte = b.address_byte + {7'd0, b.direction};
         bytes_left = {1'b0, b.length};
         txn_active = 1'b1;
         a.control_set = CTL_EN | CTL_START;
         a.control_clear = CTL_SI;
      end else if (!txn_active) begin
         a.outcome = OUT_IDLE;
      end else begin
         case (b.status_code)
            ST_START_SENT: begin
               a.data_write_valid = 1'b1;
               a.data_write_byte = target_byte;
               a.control_clear = CTL_START | CTL_STOP | CTL_SI;
            end
            ST_SLA_W_ACK: begin
               // A write of zero bytes has nothing to send after the address.
               if (bytes_left != 9'd0) begin
                  bytes_left = bytes_left - 9'd1;
                  a.data_write_valid = 1'b1;
                  a.data_write_byte = b.tx_data;
                  a.tx_consumed = 1'b1;
                  a.control_clear = CTL_SI;
               end else begin
                  a.outcome = OUT_ERR;
               end
            end
            ST_SLA_W_NACK, ST_SLA_R_NACK: begin
               a.control_clear = CTL_START;
               a.outcome = OUT_ERR;
            end
            ST_DATA_TX_ACK: begin
               if (bytes_left != 9'd0) begin
                  bytes_left = bytes_left - 9'd1;
                  a.data_write_valid = 1'b1;
                  a.data_write_byte = b.tx_data;
                  a.tx_consumed = 1'b1;
                  a.control_clear = CTL_START | CTL_STOP | CTL_SI;
               end else begin
                  a.control_set = CTL_STOP;
                  a.control_clear = CTL_START | CTL_SI;
                  a.outcome = OUT_DONE;
               end
            end
            ST_DATA_TX_NACK: begin
               a.control_clear = CTL_START;
               a.control_set = CTL_STOP;
               a.outcome = OUT_ERR;
            end
            ST_SLA_R_ACK, ST_DATA_RX_ACK: begin
               // The count saturates at zero, so a read of zero bytes acts as a read of one.
               if (bytes_left != 9'd0)
                  bytes_left = bytes_left - 9'd1;
               a.control_clear = CTL_START | CTL_STOP | CTL_SI;
               if (bytes_left != 9'd0)
                  a.control_set = CTL_ACK;
               else
                  a.control_clear = a.control_clear | CTL_ACK;
               if (b.status_code == ST_DATA_RX_ACK) begin
                  a.rx_valid = 1'b1;
                  a.rx_byte = b.rx_data;
               end
            end
            ST_DATA_RX_NACK: begin
               // The slave may only be refused on the last byte; earlier is an error.
               if (bytes_left != 9'd0) begin
                  a.outcome = OUT_ERR;
               end else begin
                  a.rx_valid = 1'b1;
                  a.rx_byte = b.rx_data;
                  a.outcome = OUT_DONE;
               end
               a.control_clear = CTL_START | CTL_SI;
               a.control_set = CTL_STOP;
            end
            // Repeated start, arbitration lost and every unknown code end here.
            default: a.outcome = OUT_ERR;
         endcase
         if (a.outcome != OUT_BUSY)
            txn_active = 1'b0;
      end
      return a;
   endfunction

   task automatic add_row(input req_type b, input logic typed, input rsp_type g);
      directed_row_type r;
      r.beat = b;
      r.typed = typed;
      r.golden = g;
      directed_rows.push_back(r);
   endtask

   // Offers one request beat, starting at a falling edge, after a random idle stretch.
   // Valid and the payload hold until the beat is taken. The task returns at the falling
   // edge after acceptance, so the next beat keeps valid high with a single assignment.
   task automatic offer(input req_type b, input logic typed = 1'b0, input rsp_type golden = '0);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= b.opcode;
      req_address_byte <= b.address_byte;
      req_direction    <= b.direction;
      req_length       <= b.length;
      req_status_code  <= b.status_code;
      req_rx_data      <= b.rx_data;
      req_tx_data      <= b.tx_data;
      do
         @(posedge clock);
      while (req_stall);
      predicted = next_action(b);
      if (predicted.outcome != OUT_IDLE)
         state_beats++;
      expected_actions.push_back(typed ? golden : predicted);
      @(negedge clock);
   endtask

   // A status event with random payload. Now and then the intended code is replaced by
   // a random byte, by another known code, or by a stray start, so that broken
   // sequences are mixed into the well-formed ones.
   function automatic req_type event_beat(input logic [7:0] code);
      req_type     b;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      b = raw[$bits(req_type)-1:0];
      b.opcode = OP_EVENT;
      b.status_code = code;
      case ($urandom_range(0, 49))
         0: b.status_code = 8'($urandom_range(0, 255));
         1: begin
            case ($urandom_range(0, 10))
               0: b.status_code = ST_START_SENT;
               1: b.status_code = ST_SLA_W_ACK;
               2: b.status_code = ST_SLA_W_NACK;
               3: b.status_code = ST_DATA_TX_ACK;
               4: b.status_code = ST_DATA_TX_NACK;
               5: b.status_code = ST_SLA_R_ACK;
               6: b.status_code = ST_SLA_R_NACK;
               7: b.status_code = ST_DATA_RX_ACK;
               8: b.status_code = ST_DATA_RX_NACK;
               9: b.status_code = ST_REPEATED_START;
               default: b.status_code = ST_ARB_LOST;
            endcase
         end
         2: b.opcode = OP_START;
         default: ;
      endcase
      return b;
   endfunction

   // One transfer as the controller would report it: start, address sent, then the data
   // phase in the chosen direction. Long lengths are cut short after at most six bytes: a cut
   // read ends in error on the early refusal, and a cut write is replaced by the next start.
   task automatic random_transfer();
      req_type     b;
      logic [63:0] raw;
      int unsigned body;
      int unsigned n;
      raw = {$urandom, $urandom};
      b = raw[$bits(req_type)-1:0];
      b.opcode = OP_START;
      case ($urandom_range(0, 9))
         0: b.length = 8'd0;
         1, 2: b.length = 8'($urandom_range(0, 255));
         default: b.length = 8'($urandom_range(1, 4));
      endcase
      body = (b.length > 6) ? $urandom_range(0, 6) : b.length;
      offer(b);
      offer(event_beat(ST_START_SENT));
      if (b.direction) begin
         offer(event_beat(ST_SLA_R_ACK));
         for (n = 1; n < body; n++)
            offer(event_beat(ST_DATA_RX_ACK));
         offer(event_beat(ST_DATA_RX_NACK));
      end else begin
         // The address acknowledge sends the first byte; each data acknowledge sends the
         // next, and the one after the last byte finishes the transfer.
         offer(event_beat(ST_SLA_W_ACK));
         for (n = 0; n < body; n++)
            offer(event_beat(ST_DATA_TX_ACK));
      end
      // Events between transfers exercise the idle path; the block ignores them when no transfer is running.
      if ($urandom_range(0, 9) == 0)
         offer(event_beat(8'($urandom_range(0, 255))));
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Every result beat taken at a rising edge is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_data_write_valid, rsp_data_write_byte, rsp_tx_consumed, rsp_control_set,
                rsp_control_clear, rsp_rx_valid, rsp_rx_byte, rsp_outcome};
         if (expected_actions.size() == 0) begin
            $error("result beat with no request pending: 0x%0h", got);
            error_count++;
         end else begin
            want = expected_actions.pop_front();
            compare_field("data_write_valid", want.data_write_valid, got.data_write_valid);
            compare_field("data_write_byte", want.data_write_byte, got.data_write_byte);
            compare_field("tx_consumed", want.tx_consumed, got.tx_consumed);
            compare_field("control_set", want.control_set, got.control_set);
            compare_field("control_clear", want.control_clear, got.control_clear);
            compare_field("rx_valid", want.rx_valid, got.rx_valid);
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("outcome", want.outcome, got.outcome);
         end
      end
   end

   // The receiver stalls at random, at the rate of the current phase. When asked, it holds
   // off for a long stretch so that the result buffer fills and the block stalls its input.
   initial begin : receiver
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   initial begin : sender
      int unsigned i;
      int unsigned phase;
      int unsigned goal;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_START;
      req_address_byte = 8'h00;
      req_direction    = 1'b0;
      req_length       = 8'h00;
      req_status_code  = 8'h00;
      req_rx_data      = 8'h00;
      req_tx_data      = 8'h00;

      // Directed table. The fields are opcode, address, direction, length, status, received
      // byte and transmit byte.
      // An event right after reset finds no transfer and is ignored.
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_START_SENT, 8'h00, 8'h00}, 1'b1, IDLE_ACTION);
      // Address 0xFF plus the read bit wraps around to 0x00.
      add_row({OP_START, 8'hFF, 1'b1, 8'h01, 8'hFF, 8'hFF, 8'hFF}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'hFF, 1'b1, 8'hFF, ST_START_SENT, 8'h00, 8'h00}, 1'b0, '0);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_SLA_W_ACK, 8'h00, 8'hFF}, 1'b0, '0);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_TX_ACK, 8'hFF, 8'h00}, 1'b0, '0);
      // A write of zero bytes fails on the address acknowledge.
      add_row({OP_START, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_SLA_W_ACK, 8'h00, 8'hFF}, 1'b1, BARE_ERROR);
      // A read of zero bytes saturates the count and reads one byte.
      add_row({OP_START, 8'hA0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_SLA_R_ACK, 8'h00, 8'h00}, 1'b0, '0);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_RX_NACK, 8'hFF, 8'h00}, 1'b0, '0);
      // Starts while a transfer is running replace it.
      add_row({OP_START, 8'h54, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_START, 8'hFE, 1'b0, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_TX_ACK, 8'h00, 8'h00}, 1'b0, '0);
      add_row({OP_START, 8'h12, 1'b1, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_RX_ACK, 8'hAA, 8'h00}, 1'b0, '0);
      // Each refusal and each unlisted code ends the transfer in error.
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_SLA_W_NACK, 8'h00, 8'h00}, 1'b1,
              ADDR_NACK_ERROR);
      add_row({OP_START, 8'h00, 1'b0, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_TX_NACK, 8'h00, 8'h00}, 1'b1,
              DATA_NACK_ERROR);
      add_row({OP_START, 8'h32, 1'b1, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_SLA_R_NACK, 8'h00, 8'h00}, 1'b1,
              ADDR_NACK_ERROR);
      add_row({OP_START, 8'h32, 1'b1, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_DATA_RX_NACK, 8'h77, 8'h00}, 1'b1,
              EARLY_NACK_ERROR);
      add_row({OP_START, 8'h20, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_REPEATED_START, 8'h00, 8'h00}, 1'b1, BARE_ERROR);
      add_row({OP_START, 8'h20, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, ST_ARB_LOST, 8'h00, 8'h00}, 1'b1, BARE_ERROR);
      add_row({OP_START, 8'h20, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1, START_ACTION);
      add_row({OP_EVENT, 8'h00, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00}, 1'b1, BARE_ERROR);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < directed_rows.size(); i++)
         offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].golden);

      // Three random phases: a slow receiver, then a slow sender, then full rate with one
      // long hold-off of the receiver while the sender keeps offering beats.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               rcv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               rcv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
               hold_off_pending = 1'b1;
            end
         endcase
         goal = state_beats + RANDOM_BEATS / 3;
         while (state_beats < goal)
            random_transfer();
      end

      req_valid <= 1'b0;
      while (expected_actions.size() != 0)
         @(posedge clock);
      // Keeps clocking to catch a result beat that should not be there.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("i2c_master_status_sequencer_unit_tb: clean");
      else
         $display("i2c_master_status_sequencer_unit_tb: errors");
      $finish;
   end

endmodule

@@ files.f @@
design/i2cms_pkg.sv
design/i2cms_core.sv
design/i2cms_outbuf.sv
design/i2c_master_status_sequencer_unit.sv
tb/sv/i2c_master_status_sequencer_unit_tb.sv
